### rtl/core/ddw_pkg.sv
// shared types and constants of the discrete delta weight block
`timescale 1ns / 1ps
`default_nettype none
package ddw_pkg;

  // configuration address space
  localparam int ADDR_W = 3;
  localparam logic [0:0] REG_GRID_SPACING = 1'b0;

  // one marker-cell pair
  typedef struct packed {
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
  } pair_word_t;

  // one weight result
  typedef struct packed {
    logic [31:0] weight;
    logic        in_support;
  } weight_word_t;

  // status of a lane's output stage
  typedef struct packed {
    logic valid;
    logic in_range;
  } lane_stat_t;

endpackage
`default_nettype wire

### rtl/core/discrete_delta_weight_2d.sv
// 2-d three-point discrete delta weight: two axis lanes and merging divide stages
// throughput one word per cycle while the weight side does not stall, set by fully pipelined dividers and square roots
// a stall on the weight side freezes the whole pipeline and stalls the pair side
// synchronous reset clears all valid flags and sets grid_spacing to 1.0
`timescale 1ns / 1ps
`default_nettype none
module discrete_delta_weight_2d
  import ddw_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pt_valid,
  output logic                   pt_stall,
  input  wire pair_word_t        pt,
  output logic                   wt_valid,
  input  wire logic              wt_stall,
  output weight_word_t           wt,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int F   = FRAC_BITS;
  localparam int NBW = 2 * F;
  localparam int N2W = 3 * F + 64;

  // configuration register
  logic [31:0] grid_spacing;
  logic [31:0] h;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_spacing <= 32'(1) << F;
    end else if (psel && penable && pwrite && paddr[2:2] == REG_GRID_SPACING) begin
      grid_spacing <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == REG_GRID_SPACING) ? grid_spacing : 32'd0;
  assign h      = (grid_spacing == 32'd0) ? 32'd1 : grid_spacing;

  // pipeline advance
  logic en;
  assign pt_stall = wt_valid && wt_stall;
  assign en       = !pt_stall;

  // offset magnitudes
  logic [31:0] mag_x, mag_y;
  assign mag_x = pt.offset_x[31] ? 32'(-pt.offset_x) : pt.offset_x;
  assign mag_y = pt.offset_y[31] ? 32'(-pt.offset_y) : pt.offset_y;

  // axis lanes
  lane_stat_t  stat_x, stat_y;
  logic [F-1:0] phi_x, phi_y;

  ddw_lane #(.FRAC_BITS(F)) u_lane_x (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .in_v (pt_valid),
    .mag  (mag_x),
    .h    (h),
    .stat (stat_x),
    .phi  (phi_x)
  );

  ddw_lane #(.FRAC_BITS(F)) u_lane_y (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .in_v (pt_valid),
    .mag  (mag_y),
    .h    (h),
    .stat (stat_y),
    .phi  (phi_y)
  );

  // merge: product of both axis kernels
  logic           m_v, m_supp;
  logic [NBW-1:0] m_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (en) begin
      m_v <= stat_x.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_n    <= phi_x * phi_y;
      m_supp <= stat_x.in_range && stat_y.in_range;
    end
  end

  // t = n / h
  logic           t_v;
  logic [NBW-1:0] t_q;
  logic           t_supp;

  ddw_div #(.QB(NBW), .SW(1)) u_div_t (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_v   (m_v),
    .rem_in (32'd0),
    .num_in (m_n),
    .sb_in  (m_supp),
    .h      (h),
    .out_v  (t_v),
    .quo    (t_q),
    .sb_out (t_supp)
  );

  // second divide set-up and saturation test
  logic           s_v, s_sat, s_supp;
  logic [31:0]    s_rem, s_low;
  logic [N2W-1:0] num2, num2_hi;
  assign num2    = {{(N2W - NBW - F){1'b0}}, t_q, {F{1'b0}}};
  assign num2_hi = num2 >> 32;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_v <= 1'b0;
    end else if (en) begin
      s_v <= t_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_sat  <= num2_hi >= N2W'(h);
      s_rem  <= num2[63:32];
      s_low  <= num2[31:0];
      s_supp <= t_supp;
    end
  end

  // w = t * 2^F / h
  logic        w_v;
  logic [31:0] w_q;
  logic [1:0]  w_sb;

  ddw_div #(.QB(32), .SW(2)) u_div_w (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_v   (s_v),
    .rem_in (s_rem),
    .num_in (s_low),
    .sb_in  ({s_supp, s_sat}),
    .h      (h),
    .out_v  (w_v),
    .quo    (w_q),
    .sb_out (w_sb)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      wt_valid <= 1'b0;
    end else if (en) begin
      wt_valid <= w_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wt.weight     <= w_sb[0] ? 32'hFFFF_FFFF : w_q;
      wt.in_support <= w_sb[1];
    end
  end

  // checks
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    stat_x.valid == stat_y.valid)
    else $error("axis lanes out of step");

  a_no_support_zero: assert property (@(posedge clk) disable iff (rst)
    wt_valid && !wt.in_support |-> wt.weight == 32'd0)
    else $error("weight nonzero outside support");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    wt_valid && wt_stall |=> wt_valid && $stable(wt))
    else $error("stalled weight word changed");

  a_spacing_nonzero: assert property (@(posedge clk) disable iff (rst)
    h != 32'd0)
    else $error("effective grid spacing is zero");

endmodule
`default_nettype wire

### rtl/core/ddw_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module ddw_div #(
  parameter int QB = 17,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_v,
  input  wire logic [31:0]   rem_in,
  input  wire logic [QB-1:0] num_in,
  input  wire logic [SW-1:0] sb_in,
  input  wire logic [31:0]   h,
  output logic               out_v,
  output logic [QB-1:0]      quo,
  output logic [SW-1:0]      sb_out
);

  logic          v   [0:QB];
  logic [31:0]   rem [0:QB];
  logic [QB-1:0] nb  [0:QB];
  logic [QB-1:0] qq  [0:QB];
  logic [SW-1:0] sb  [0:QB];

  assign v[0]   = in_v;
  assign rem[0] = rem_in;
  assign nb[0]  = num_in;
  assign qq[0]  = '0;
  assign sb[0]  = sb_in;

  // one shift-and-subtract step per stage
  for (genvar i = 1; i <= QB; i++) begin : g_stage
    logic [32:0] trial;
    logic        ge;
    assign trial = {rem[i-1], nb[i-1][QB-1]};
    assign ge    = trial >= {1'b0, h};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= v[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? 32'(trial - {1'b0, h}) : trial[31:0];
        nb[i]  <= {nb[i-1][QB-2:0], 1'b0};
        qq[i]  <= {qq[i-1][QB-2:0], ge};
        sb[i]  <= sb[i-1];
      end
    end
  end

  assign out_v  = v[QB];
  assign quo    = qq[QB];
  assign sb_out = sb[QB];

endmodule
`default_nettype wire

### rtl/core/ddw_sqrt.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module ddw_sqrt #(
  parameter int RB = 17,
  parameter int SW = 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_v,
  input  wire logic [2*RB-1:0] rad_in,
  input  wire logic [SW-1:0]   sb_in,
  output logic                 out_v,
  output logic [RB-1:0]        root_out,
  output logic [SW-1:0]        sb_out
);

  logic            v    [0:RB];
  logic [RB+1:0]   rem  [0:RB];
  logic [2*RB-1:0] rad  [0:RB];
  logic [RB-1:0]   root [0:RB];
  logic [SW-1:0]   sb   [0:RB];

  assign v[0]    = in_v;
  assign rem[0]  = '0;
  assign rad[0]  = rad_in;
  assign root[0] = '0;
  assign sb[0]   = sb_in;

  // bring down two radicand bits and try the next root bit
  for (genvar i = 1; i <= RB; i++) begin : g_stage
    logic [RB+3:0] cur;
    logic [RB+3:0] sub;
    logic          ge;
    assign cur = {rem[i-1], rad[i-1][2*RB-1:2*RB-2]};
    assign sub = {2'b00, root[i-1], 2'b01};
    assign ge  = cur >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= v[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= ge ? (RB+2)'(cur - sub) : cur[RB+1:0];
        rad[i]  <= {rad[i-1][2*RB-3:0], 2'b00};
        root[i] <= {root[i-1][RB-2:0], ge};
        sb[i]   <= sb[i-1];
      end
    end
  end

  assign out_v    = v[RB];
  assign root_out = root[RB];
  assign sb_out   = sb[RB];

endmodule
`default_nettype wire

### rtl/core/ddw_lane.sv
// one axis lane: three-point kernel value of a single offset
`timescale 1ns / 1ps
`default_nettype none
module ddw_lane
  import ddw_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_v,
  input  wire logic [31:0]          mag,
  input  wire logic [31:0]          h,
  output lane_stat_t                stat,
  output logic [FRAC_BITS-1:0]      phi
);

  localparam int F  = FRAC_BITS;
  localparam int RW = F + 1;
  localparam int SQW = 2 * F + 4;
  localparam int NW = F + 4;
  localparam int K  = F + 4;
  localparam logic [RW-1:0]  ONE  = RW'(1) << F;
  localparam logic [SQW-1:0] ONE2 = SQW'(1) << (2 * F);
  localparam logic [NW-1:0]  FIVE = NW'(5) << F;
  localparam logic [K-1:0]   M3   = K'((64'd1 << K) / 3);
  localparam logic [K-1:0]   M6   = K'((64'd1 << K) / 6);

  // stage a: support and branch tests
  logic        a_v, a_inside, a_outer;
  logic [31:0] a_mag;
  logic [33:0] h3;
  assign h3 = {2'b00, h} + {1'b0, h, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag    <= mag;
      a_inside <= !({1'b0, mag, 1'b0} > h3);
      a_outer  <= {1'b0, mag, 1'b0} > {2'b00, h};
    end
  end

  // r = mag * 2^F / h
  logic          r_v;
  logic [RW-1:0] r_q;
  logic [1:0]    r_sb;

  ddw_div #(.QB(RW), .SW(2)) u_div_r (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_v   (a_v),
    .rem_in ({1'b0, a_mag[31:1]}),
    .num_in ({a_mag[0], {F{1'b0}}}),
    .sb_in  ({a_inside, a_outer}),
    .h      (h),
    .out_v  (r_v),
    .quo    (r_q),
    .sb_out (r_sb)
  );

  // stage b: pick r or |1 - r|
  logic          b_v, b_inside, b_outer;
  logic [RW-1:0] b_r, b_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= r_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_r      <= r_q;
      b_inside <= r_sb[1];
      b_outer  <= r_sb[0];
      if (!r_sb[0]) begin
        b_x <= r_q;
      end else if (r_q >= ONE) begin
        b_x <= r_q - ONE;
      end else begin
        b_x <= ONE - r_q;
      end
    end
  end

  // stage c: square
  logic            c_v, c_inside, c_outer;
  logic [RW-1:0]   c_r;
  logic [2*RW-1:0] c_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sq     <= b_x * b_x;
      c_r      <= b_r;
      c_inside <= b_inside;
      c_outer  <= b_outer;
    end
  end

  // stage d: radicand 1 - 3 x^2, clamped at zero
  logic           d_v, d_inside, d_outer;
  logic [RW-1:0]  d_r;
  logic [2*RW-1:0] d_s;
  logic [SQW-1:0] sub3;
  assign sub3 = {2'b00, c_sq} + {1'b0, c_sq, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_s      <= (sub3 >= ONE2) ? '0 : (2*RW)'(ONE2 - sub3);
      d_r      <= c_r;
      d_inside <= c_inside;
      d_outer  <= c_outer;
    end
  end

  // square root of the radicand
  logic          q_v;
  logic [RW-1:0] q_root;
  logic [RW+1:0] q_sb;

  ddw_sqrt #(.RB(RW), .SW(RW + 2)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (d_v),
    .rad_in   (d_s),
    .sb_in    ({d_inside, d_outer, d_r}),
    .out_v    (q_v),
    .root_out (q_root),
    .sb_out   (q_sb)
  );

  // stage e: kernel numerator of the chosen branch
  logic          e_v, e_inside, e_outer;
  logic [NW-1:0] e_num;
  logic [NW-1:0] q_r3, q_sum;
  assign q_r3  = {3'b000, q_sb[RW-1:0]} + {2'b00, q_sb[RW-1:0], 1'b0};
  assign q_sum = q_r3 + {3'b000, q_root};

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en) begin
      e_v <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_inside <= q_sb[RW+1];
      e_outer  <= q_sb[RW];
      if (q_sb[RW]) begin
        e_num <= (q_sum >= FIVE) ? '0 : FIVE - q_sum;
      end else begin
        e_num <= {3'b000, ONE} + {3'b000, q_root};
      end
    end
  end

  // stage f: reciprocal multiply for /3 or /6
  logic            f_v, f_inside, f_outer;
  logic [NW-1:0]   f_num;
  logic [NW+K-1:0] f_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (en) begin
      f_v <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_prod   <= e_num * (e_outer ? M6 : M3);
      f_num    <= e_num;
      f_inside <= e_inside;
      f_outer  <= e_outer;
    end
  end

  // stage g: zero outside the support, else correct the estimate by one where it fell short
  logic          g_v, g_inside;
  logic [F-1:0]  g_phi;
  logic [NW-1:0] est, est_mul, est_rem, dvs;
  assign dvs     = f_outer ? NW'(6) : NW'(3);
  assign est     = f_prod[NW+K-1:K];
  assign est_mul = f_outer ? ({est[NW-2:0], 1'b0} + {est[NW-3:0], 2'b00})
                           : ({est[NW-2:0], 1'b0} + est);
  assign est_rem = f_num - est_mul;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (en) begin
      g_v <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_inside <= f_inside;
      if (!f_inside) begin
        g_phi <= '0;
      end else if (est_rem >= dvs) begin
        g_phi <= F'(est + NW'(1));
      end else begin
        g_phi <= est[F-1:0];
      end
    end
  end

  assign stat.valid    = g_v;
  assign stat.in_range = g_inside;
  assign phi           = g_phi;

endmodule
`default_nettype wire
